[rtl/temc_pkg.sv]
// Shared types and constants for the edge-pair motif counter.
package temc_pkg;
  localparam int unsigned NodesDefault = 256;
  localparam int unsigned NodeW = 8;
  localparam int unsigned DegW = 9;
  localparam int unsigned CntW = 17;
  localparam int unsigned SumW = 25;
  localparam int unsigned OutW = 32;
  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic [NodeW-1:0] row;
    logic [NodeW-1:0] col;
    logic             add;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [CntW-1:0] edges;
    logic [CntW-1:0] trace;
    logic [SumW-1:0] rsq;
    logic [SumW-1:0] csq;
    logic [SumW-1:0] xsum;
  } totals_t;
endpackage

[rtl/temc_ram.sv]
// Generic single-port RAM with registered read.
module temc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

[rtl/temc_front.sv]
// Front end: range check, classification and a small item queue.
module temc_front #(
  parameter int unsigned Nodes = temc_pkg::NodesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [temc_pkg::NodeW-1:0]     row_node_i,
  input  logic [temc_pkg::NodeW-1:0]     col_node_i,
  input  logic                           edge_bit_i,
  input  logic                           last_entry_i,
  output logic                           full_o,
  output logic                           valid_o,
  output temc_pkg::item_t                item_o,
  input  logic                           pop_i
);
  temc_pkg::item_t  q_q [temc_pkg::QDepth];
  logic             rd_q, wr_q;
  logic [1:0]       cnt_q;
  temc_pkg::item_t  in_item;
  logic             in_range;

  assign in_range = ({5'd0, row_node_i} < 13'(Nodes)) && ({5'd0, col_node_i} < 13'(Nodes));
  assign in_item = '{row: row_node_i, col: col_node_i,
                     add: edge_bit_i & in_range, last: last_entry_i};
  assign full_o  = (cnt_q == 2'(temc_pkg::QDepth));
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = q_q[rd_q];

  always_ff @(posedge clk_i) if (push_i) q_q[wr_q] <= in_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

[rtl/temc_back.sv]
// Back end: bitmap and degree updates, running sums, result formation.
module temc_back #(
  parameter int unsigned Nodes = temc_pkg::NodesDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  temc_pkg::item_t            item_i,
  output logic                       pop_o,
  output logic                       result_valid_o,
  output logic [16:0]                edge_count_o,
  output logic [16:0]                recip_trace_o,
  output logic [23:0]                conv_count_o,
  output logic [23:0]                div_count_o,
  output logic [24:0]                chain_count_o,
  output logic [31:0]                other_count_x2_o
);
  localparam int unsigned AW = $clog2(Nodes);
  localparam int unsigned BW = 2 * AW;
  localparam int unsigned DW = temc_pkg::DegW;

  typedef enum logic [7:0] {
    StIdle = 8'b00000001, StRd1 = 8'b00000010, StChk = 8'b00000100,
    StRow  = 8'b00001000, StCol = 8'b00010000, StFin = 8'b00100000,
    StMul  = 8'b01000000, StClr = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  temc_pkg::item_t it_q;
  temc_pkg::totals_t tot_q;
  logic epoch_q;
  logic [BW-1:0]  clr_q;

  logic           bm_we;
  logic [BW-1:0]  bm_addr;
  logic [1:0]     bm_wd, bm_rd;
  logic           rs_we, cs_we;
  logic [AW-1:0]  rs_addr, cs_addr;
  logic [DW:0]    rs_wd, cs_wd, rs_rd, cs_rd;
  logic [DW-1:0]  r_deg, cr_deg, rj_deg, cj_deg;
  logic           bm_live;
  logic           recip_q, self_q;
  logic [DW-1:0]  ri_q, cri_q, cj_h, rj_h;
  logic [31:0]    ee_q;

  logic [AW-1:0] ri, ci;
  assign ri = AW'(it_q.row);
  assign ci = AW'(it_q.col);
  assign bm_live = (bm_rd[1] == epoch_q) && bm_rd[0];

  function automatic logic [DW-1:0] live_deg(logic [DW:0] v, logic ep);
    live_deg = (v[DW] == ep) ? v[DW-1:0] : '0;
  endfunction

  temc_ram #(.Width(2), .Depth(1 << BW)) u_bm (
    .clk_i, .we_i(bm_we), .addr_i(bm_addr), .wdata_i(bm_wd), .rdata_o(bm_rd));
  temc_ram #(.Width(DW+1), .Depth(1 << AW)) u_rdeg (
    .clk_i, .we_i(rs_we), .addr_i(rs_addr), .wdata_i(rs_wd), .rdata_o(rs_rd));
  temc_ram #(.Width(DW+1), .Depth(1 << AW)) u_cdeg (
    .clk_i, .we_i(cs_we), .addr_i(cs_addr), .wdata_i(cs_wd), .rdata_o(cs_rd));

  // Addresses set in StRd1 return (i,j), row[i], col[i] in StChk;
  // addresses set in StChk return (j,i), row[j], col[j] in StRow.
  assign r_deg  = live_deg(rs_rd, epoch_q);
  assign cr_deg = live_deg(cs_rd, epoch_q);
  // row[j] after the row update when j == i (self loop)
  assign rj_deg = self_q ? ri_q + DW'(1) : live_deg(rs_rd, epoch_q);
  assign cj_deg = live_deg(cs_rd, epoch_q);

  always_comb begin
    state_d = state_q;
    bm_we = 1'b0; rs_we = 1'b0; cs_we = 1'b0;
    bm_addr = {ri, ci}; rs_addr = ri; cs_addr = ri;
    bm_wd = {epoch_q, 1'b1};
    rs_wd = {epoch_q, ri_q + DW'(1)};
    cs_wd = {epoch_q, cj_deg + DW'(1)};
    pop_o = 1'b0;
    case (state_q)
      StClr: begin
        bm_we = 1'b1; rs_we = 1'b1; cs_we = 1'b1;
        bm_addr = clr_q; rs_addr = clr_q[AW-1:0]; cs_addr = clr_q[AW-1:0];
        bm_wd = '0; rs_wd = '0; cs_wd = '0;
        state_d = (clr_q == '1) ? StIdle : StClr;
      end
      StIdle: if (valid_i) begin
        pop_o = 1'b1;
        state_d = item_i.add ? StRd1 : (item_i.last ? StMul : StIdle);
      end
      StRd1: state_d = StChk;
      StChk: begin
        bm_addr = {ci, ri}; rs_addr = ci; cs_addr = ci;
        state_d = bm_live ? (it_q.last ? StMul : StIdle) : StRow;
      end
      StRow: begin
        bm_we = 1'b1; rs_we = 1'b1; rs_addr = ri;
        cs_addr = ci;
        state_d = StCol;
      end
      StCol: begin
        cs_we = 1'b1; cs_addr = ci;
        state_d = it_q.last ? StMul : StIdle;
      end
      StMul: state_d = StFin;
      StFin: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) it_q <= item_i;
    if (state_q == StChk) begin
      ri_q <= r_deg; cri_q <= cr_deg; self_q <= (ri == ci);
    end
    // (j,i) check and column-side degrees arrive in StRow
    if (state_q == StRow) begin
      recip_q <= bm_live; cj_h <= cj_deg; rj_h <= rj_deg;
    end
    if (state_q == StMul) ee_q <= 32'(tot_q.edges) * 32'(tot_q.edges - 17'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr; epoch_q <= 1'b0; tot_q <= '0; clr_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StClr) clr_q <= clr_q + 1'b1;
      case (state_q)
        StRow: begin
          tot_q.rsq  <= tot_q.rsq + temc_pkg::SumW'({ri_q, 1'b1});
          tot_q.xsum <= tot_q.xsum + temc_pkg::SumW'(cri_q);
        end
        StCol: begin
          tot_q.csq   <= tot_q.csq + temc_pkg::SumW'({cj_h, 1'b1});
          tot_q.xsum  <= tot_q.xsum + temc_pkg::SumW'(rj_h);
          tot_q.edges <= tot_q.edges + 17'd1;
          if (self_q) tot_q.trace <= tot_q.trace + 17'd1;
          else if (recip_q) tot_q.trace <= tot_q.trace + 17'd2;
        end
        StFin: begin
          tot_q <= '0; epoch_q <= ~epoch_q;
        end
        default: ;
      endcase
    end
  end

  logic [24:0] conv2, div2, chain;
  assign conv2 = tot_q.rsq - 25'(tot_q.edges);
  assign div2  = tot_q.csq - 25'(tot_q.edges);
  assign chain = tot_q.xsum - 25'(tot_q.trace);
  assign result_valid_o  = (state_q == StFin);
  assign edge_count_o    = tot_q.edges;
  assign recip_trace_o   = tot_q.trace;
  assign conv_count_o    = conv2[24:1];
  assign div_count_o     = div2[24:1];
  assign chain_count_o   = chain;
  assign other_count_x2_o = ee_q - 32'(conv2) - 32'(div2) - {6'd0, chain, 1'b0}
                            - 32'(tot_q.trace);
endmodule

[rtl/two_edge_motif_counter_core.sv]
// Top level of the edge-pair motif counter.
// Usage: drive row_node_i, col_node_i, edge_bit_i, last_entry_i with start
// high; the item is taken at a clock edge where busy is low. Entries of one
// graph come in any order; the entry with last_entry_i set closes the graph.
// Results: one item on the *_o result ports, marked by done_o for one cycle.
// In the back end an entry that adds a new edge steps through pop, bitmap
// and degree RAM read, duplicate check, row then column update; a repeated
// edge stops after the check, others after the pop. A closing entry then
// adds a multiply and a result step, and done_o is high in the result step.
// The receiver cannot stall. A two-entry queue decouples the input from
// that sequencer, so busy rises only when the queue is full. Reset clears
// all sums and the epoch bit, then the back end writes zeros to every RAM
// entry, one bitmap entry per cycle (65536 entries for 256 nodes); up to
// two items queue meanwhile. Later graphs get no clearing: the epoch tag
// marks entries of the previous graph as stale, and each graph flips it.
module two_edge_motif_counter_core #(
  parameter int unsigned Nodes = temc_pkg::NodesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  row_node_i,
  input  logic [7:0]  col_node_i,
  input  logic        edge_bit_i,
  input  logic        last_entry_i,
  output logic        done_o,
  output logic [16:0] edge_count_o,
  output logic [16:0] recip_trace_o,
  output logic [23:0] conv_count_o,
  output logic [23:0] div_count_o,
  output logic [24:0] chain_count_o,
  output logic [31:0] other_count_x2_o
);
  logic full, qv, pop;
  temc_pkg::item_t it;
  assign busy = full;

  temc_front #(.Nodes(Nodes)) u_front (
    .clk_i, .rst_ni, .push_i(start & ~full), .row_node_i, .col_node_i,
    .edge_bit_i, .last_entry_i, .full_o(full), .valid_o(qv), .item_o(it),
    .pop_i(pop));

  temc_back #(.Nodes(Nodes)) u_back (
    .clk_i, .rst_ni, .valid_i(qv), .item_i(it), .pop_o(pop),
    .result_valid_o(done_o), .edge_count_o, .recip_trace_o, .conv_count_o,
    .div_count_o, .chain_count_o, .other_count_x2_o);
endmodule

[rtl/temc_checker.sv]
// Port-level checks for the edge-pair motif counter.
module temc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy,
  input logic done_o,
  input logic [16:0] edge_count_o,
  input logic [16:0] recip_trace_o
);
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held two cycles");
  a_idle_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !done_o) else $error("result out of reset");
  a_ctrl_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({busy, done_o})) else $error("busy or done unknown");
  a_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown({edge_count_o, recip_trace_o}))
    else $error("result fields unknown");
endmodule

bind two_edge_motif_counter_core temc_checker u_chk (
  .clk_i, .rst_ni, .busy, .done_o, .edge_count_o, .recip_trace_o);
